### hw/rtl/thin_plate_spline_evaluate_macros.svh
// Assertion macros shared by the spline evaluator RTL.
`ifndef THIN_PLATE_SPLINE_EVALUATE_MACROS_SVH
`define THIN_PLATE_SPLINE_EVALUATE_MACROS_SVH

// Checked on every clock edge outside reset.
`define TPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define TPS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hw/rtl/tps_eval_pkg.sv
// Shared types, widths and the log2 mantissa table of the spline evaluator.
`timescale 1ns / 1ps
package tps_eval_pkg;

    // Sizes of the block.
    localparam int MAX_POINTS_DEF = 64;
    localparam int FRAC_BITS      = 16;
    localparam int LOG_TABLE_BITS = 8;
    localparam int ROM_SIZE       = 1 << LOG_TABLE_BITS;
    localparam int L2_FRAC        = 24;
    localparam int DATA_W         = 32;
    localparam int COUNT_W        = 7;
    localparam int INDEX_W        = 6;
    localparam int ACC_W          = 64;
    localparam int REG_IDX_W      = 3;
    localparam int PADDR_W        = 5;

    // Kernel datapath widths.
    localparam int DIFF_W   = DATA_W + 1;
    localparam int SQ_W     = 2 * DIFF_W - FRAC_BITS;
    localparam int S_W      = SQ_W + 1;
    localparam int POS_W    = $clog2(S_W);
    localparam int L2_W     = 32;
    localparam int LN2_W    = 30;
    localparam logic [LN2_W-1:0] LN2_Q30 = 30'd744261118;
    localparam int LN_SHIFT = 54 - FRAC_BITS;
    localparam int LNP_W    = L2_W + LN2_W;
    localparam int LN_W     = LNP_W - LN_SHIFT;
    localparam int S_HI_W   = S_W - DATA_W;
    localparam int UP_W     = S_W + LN_W;
    localparam int U_W      = UP_W - FRAC_BITS;
    localparam int U_HI_W   = U_W - DATA_W;
    localparam int TP_W     = DATA_W + U_W;
    localparam int TM_W     = TP_W - FRAC_BITS;
    localparam int AP_W     = 2 * DATA_W;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_EVAL = 1'b1
    } t_action;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_POINT_COUNT = 3'd0,
        REG_AX_OFFSET   = 3'd1,
        REG_AX_FROM_X   = 3'd2,
        REG_AX_FROM_Y   = 3'd3,
        REG_AY_OFFSET   = 3'd4,
        REG_AY_FROM_X   = 3'd5,
        REG_AY_FROM_Y   = 3'd6
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AFF_MUL,
        ST_AFF_ADD1,
        ST_AFF_ADD2,
        ST_SUM,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        t_action                   action;
        logic [INDEX_W-1:0]        entry_index;
        logic signed [DATA_W-1:0]  ctrl_x;
        logic signed [DATA_W-1:0]  ctrl_y;
        logic signed [DATA_W-1:0]  weight_x;
        logic signed [DATA_W-1:0]  weight_y;
        logic signed [DATA_W-1:0]  query_x;
        logic signed [DATA_W-1:0]  query_y;
    } t_in_beat;

    typedef struct packed {
        logic signed [DATA_W-1:0]  mapped_x;
        logic signed [DATA_W-1:0]  mapped_y;
        logic                      saturated;
    } t_out_beat;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic capture;
        logic aff_init;
        logic aff_add1;
        logic aff_add2;
        logic cnt_clear;
        logic issue;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic none_to_sum;
        logic last_issue;
        logic pipe_busy;
        logic out_busy;
    } t_status;

    // log2(1 + k/2^T) in Q0.24, built by repeated squaring at elaboration.
    typedef logic [L2_FRAC-1:0] t_rom [ROM_SIZE];

    function automatic t_rom build_log2_rom();
        t_rom               rom;
        logic [63:0]        y;
        logic [L2_FRAC-1:0] frac;
        for (int k = 0; k < ROM_SIZE; k++) begin
            y = (64'd1 << 30) + (64'(k) << (30 - LOG_TABLE_BITS));
            frac = '0;
            for (int b = 1; b <= L2_FRAC; b++) begin
                y = (y * y) >> 30;
                if (y >= (64'd1 << 31)) begin
                    frac[L2_FRAC - b] = 1'b1;
                    y = y >> 1;
                end
            end
            rom[k] = frac;
        end
        return rom;
    endfunction

    localparam t_rom LOG2_ROM = build_log2_rom();

endpackage

### hw/rtl/tps_eval_ctrl.sv
// Sequencer that steps one evaluation through affine setup, summation and drain.
`timescale 1ns / 1ps
module tps_eval_ctrl
    import tps_eval_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_action i_action,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (i_action == ACT_EVAL) begin
                        o_cmd.capture = 1'b1;
                        n_state       = ST_AFF_MUL;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            ST_AFF_MUL: begin
                o_cmd.aff_init  = 1'b1;
                o_cmd.cnt_clear = 1'b1;
                n_state         = ST_AFF_ADD1;
            end
            ST_AFF_ADD1: begin
                o_cmd.aff_add1 = 1'b1;
                n_state        = ST_AFF_ADD2;
            end
            ST_AFF_ADD2: begin
                o_cmd.aff_add2 = 1'b1;
                n_state        = i_status.none_to_sum ? ST_DRAIN : ST_SUM;
            end
            ST_SUM: begin
                o_cmd.issue = 1'b1;
                if (i_status.last_issue) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!i_status.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/tps_eval_dp.sv
// Datapath: control point memory, kernel pipeline, accumulators and output register.
`timescale 1ns / 1ps
module tps_eval_dp
    import tps_eval_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_in_beat                 i_in_data,
    input  t_cmd                     i_cmd,
    output t_status                  o_status,
    input  logic [COUNT_W-1:0]       i_point_count,
    input  logic signed [DATA_W-1:0] i_ax_offset,
    input  logic signed [DATA_W-1:0] i_ax_from_x,
    input  logic signed [DATA_W-1:0] i_ax_from_y,
    input  logic signed [DATA_W-1:0] i_ay_offset,
    input  logic signed [DATA_W-1:0] i_ay_from_x,
    input  logic signed [DATA_W-1:0] i_ay_from_y,
    input  logic                     i_out_stall,
    output logic                     o_out_valid,
    output t_out_beat                o_out_data
);

    localparam int AW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int NSTAGE = 11;
    localparam int ENT_W  = 4 * DATA_W;

    typedef struct packed {
        logic signed [ACC_W-1:0] sum;
        logic                    sat;
    } t_sum;

    typedef struct packed {
        logic signed [DATA_W-1:0] val;
        logic                     clip;
    } t_clip;

    function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] v);
        return v[DATA_W-1] ? DATA_W'(-v) : DATA_W'(v);
    endfunction

    // Signed 64-bit add that clamps at the ends of the range.
    function automatic t_sum add_sat(input logic signed [ACC_W-1:0] a,
                                     input logic signed [ACC_W-1:0] b);
        t_sum                    r;
        logic signed [ACC_W-1:0] s;
        s = a + b;
        r.sat = 1'b0;
        r.sum = s;
        if (a[ACC_W-1] == b[ACC_W-1] && s[ACC_W-1] != a[ACC_W-1]) begin
            r.sat = 1'b1;
            r.sum = b[ACC_W-1] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return r;
    endfunction

    // Sign a truncated magnitude and clamp it to signed 64 bits.
    function automatic t_sum sign_sat(input logic [TM_W-1:0] m, input logic neg);
        t_sum             r;
        logic             over;
        logic [ACC_W-1:0] mm;
        if (neg) begin
            over = (|m[TM_W-1:ACC_W]) || (m[ACC_W-1] && (|m[ACC_W-2:0]));
        end else begin
            over = |m[TM_W-1:ACC_W-1];
        end
        mm = m[ACC_W-1:0];
        if (over) begin
            mm = neg ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        r.sat = over;
        r.sum = neg ? -$signed(mm) : $signed(mm);
        return r;
    endfunction

    function automatic t_clip clip32(input logic signed [ACC_W-1:0] a);
        t_clip r;
        r.clip = 1'b0;
        r.val  = a[DATA_W-1:0];
        if (!a[ACC_W-1] && (|a[ACC_W-2:DATA_W-1])) begin
            r.clip = 1'b1;
            r.val  = {1'b0, {(DATA_W-1){1'b1}}};
        end else if (a[ACC_W-1] && !(&a[ACC_W-2:DATA_W-1])) begin
            r.clip = 1'b1;
            r.val  = {1'b1, {(DATA_W-1){1'b0}}};
        end
        return r;
    endfunction

    // Control point memory: {weight_y, weight_x, ctrl_y, ctrl_x} per slot.
    logic [ENT_W-1:0] r_mem [MAX_POINTS];
    logic [ENT_W-1:0] r_rd;

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] w_n;
    logic signed [DATA_W-1:0] r_qx;
    logic signed [DATA_W-1:0] r_qy;

    logic [NSTAGE:1] r_v;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && (32'(i_in_data.entry_index) < MAX_POINTS)) begin
            r_mem[AW'(i_in_data.entry_index)] <= {i_in_data.weight_y, i_in_data.weight_x,
                                                  i_in_data.ctrl_y, i_in_data.ctrl_x};
        end
        if (i_cmd.issue) begin
            r_rd <= r_mem[r_cnt[AW-1:0]];
        end
    end

    // Number of slots summed, limited to the memory depth.
    always_comb begin
        if (32'(i_point_count) > MAX_POINTS) begin
            w_n = CNT_W'(MAX_POINTS);
        end else begin
            w_n = CNT_W'(i_point_count);
        end
    end

    // Slot counter and query capture.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.cnt_clear) begin
            r_cnt <= '0;
        end else if (i_cmd.issue) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_qx <= i_in_data.query_x;
            r_qy <= i_in_data.query_y;
        end
    end

    // Affine products, taken as magnitudes with a sign.
    logic [AP_W-1:0] r_apm [4];
    logic [3:0]      r_aneg;

    always_ff @(posedge i_clk) begin
        r_apm[0] <= AP_W'(mag32(i_ax_from_x)) * AP_W'(mag32(r_qx));
        r_apm[1] <= AP_W'(mag32(i_ay_from_x)) * AP_W'(mag32(r_qx));
        r_apm[2] <= AP_W'(mag32(i_ax_from_y)) * AP_W'(mag32(r_qy));
        r_apm[3] <= AP_W'(mag32(i_ay_from_y)) * AP_W'(mag32(r_qy));
        r_aneg   <= {i_ay_from_y[DATA_W-1] ^ r_qy[DATA_W-1],
                     i_ax_from_y[DATA_W-1] ^ r_qy[DATA_W-1],
                     i_ay_from_x[DATA_W-1] ^ r_qx[DATA_W-1],
                     i_ax_from_x[DATA_W-1] ^ r_qx[DATA_W-1]};
    end

    logic signed [ACC_W-1:0] w_aterm [4];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_aterm[k] = r_aneg[k] ? -$signed(ACC_W'(r_apm[k][AP_W-1:FRAC_BITS]))
                                   : $signed(ACC_W'(r_apm[k][AP_W-1:FRAC_BITS]));
        end
    end

    // Kernel pipeline payload.
    logic [DIFF_W-1:0]         r_dxm, r_dym;
    logic [SQ_W-1:0]           r_sqx, r_sqy;
    logic [S_W-1:0]            r_s, r_s5, r_s6, r_s7;
    logic [POS_W-1:0]          r_pos;
    logic                      r_nz5, r_nz6, r_nz7, r_nz8;
    logic [L2_W-1:0]           r_l2;
    logic [LNP_W-1:0]          r_lnp;
    logic                      r_lneg, r_uneg8, r_uneg9;
    logic [DATA_W+LN_W-1:0]    r_upl;
    logic [S_HI_W+LN_W-1:0]    r_uph;
    logic [U_W-1:0]            r_um;
    logic [2*DATA_W-1:0]       r_wpipe [2:9];
    logic [2*DATA_W-1:0]       r_tplx, r_tply;
    logic [DATA_W+U_HI_W-1:0]  r_tphx, r_tphy;
    logic                      r_tnegx, r_tnegy;
    logic signed [ACC_W-1:0]   r_termx, r_termy;
    logic                      r_tsat;

    logic signed [DIFF_W-1:0]  w_dx, w_dy;
    logic [2*DIFF_W-1:0]       w_sqx, w_sqy;
    logic [POS_W-1:0]          w_pos;
    logic [S_W-1:0]            w_norm;
    logic [LOG_TABLE_BITS-1:0] w_idx;
    logic [L2_W-1:0]           w_l2, w_l2m;
    logic [LN_W-1:0]           w_lnm;
    logic [UP_W-1:0]           w_up;
    logic [DATA_W-1:0]         w_wxm, w_wym;
    logic [TP_W-1:0]           w_tpx, w_tpy;
    t_sum                      w_tx, w_ty;

    // Combinational pieces of each stage.
    always_comb begin
        w_dx  = $signed({r_qx[DATA_W-1], r_qx}) - $signed({r_rd[DATA_W-1], r_rd[DATA_W-1:0]});
        w_dy  = $signed({r_qy[DATA_W-1], r_qy})
              - $signed({r_rd[2*DATA_W-1], r_rd[2*DATA_W-1:DATA_W]});
        w_sqx = r_dxm * r_dxm;
        w_sqy = r_dym * r_dym;
        // Leading-one position of the squared distance.
        w_pos = '0;
        for (int b = 0; b < S_W; b++) begin
            if (r_s[b]) begin
                w_pos = POS_W'(b);
            end
        end
        w_norm = r_s5 << (POS_W'(S_W - 1) - r_pos);
        w_idx  = w_norm[S_W-2 -: LOG_TABLE_BITS];
        w_l2   = ((L2_W'(r_pos) - L2_W'(FRAC_BITS)) << L2_FRAC)
               + L2_W'(LOG2_ROM[w_idx]);
        w_l2m  = r_l2[L2_W-1] ? -r_l2 : r_l2;
        w_lnm  = r_lnp[LNP_W-1:LN_SHIFT];
        w_up   = UP_W'(r_upl) + (UP_W'(r_uph) << DATA_W);
        w_wxm  = mag32(r_wpipe[9][DATA_W-1:0]);
        w_wym  = mag32(r_wpipe[9][2*DATA_W-1:DATA_W]);
        w_tpx  = TP_W'(r_tplx) + (TP_W'(r_tphx) << DATA_W);
        w_tpy  = TP_W'(r_tply) + (TP_W'(r_tphy) << DATA_W);
        w_tx   = sign_sat(w_tpx[TP_W-1:FRAC_BITS], r_tnegx);
        w_ty   = sign_sat(w_tpy[TP_W-1:FRAC_BITS], r_tnegy);
    end

    // Pipeline registers, one point per cycle.
    always_ff @(posedge i_clk) begin
        r_dxm <= w_dx[DIFF_W-1] ? DIFF_W'(-w_dx) : DIFF_W'(w_dx);
        r_dym <= w_dy[DIFF_W-1] ? DIFF_W'(-w_dy) : DIFF_W'(w_dy);
        r_wpipe[2] <= r_rd[ENT_W-1:2*DATA_W];
        for (int k = 3; k <= 9; k++) begin
            r_wpipe[k] <= r_wpipe[k-1];
        end
        r_sqx <= w_sqx[2*DIFF_W-1:FRAC_BITS];
        r_sqy <= w_sqy[2*DIFF_W-1:FRAC_BITS];
        r_s   <= S_W'(r_sqx) + S_W'(r_sqy);
        r_pos <= w_pos;
        r_nz5 <= |r_s;
        r_s5  <= r_s;
        r_l2  <= w_l2;
        r_nz6 <= r_nz5;
        r_s6  <= r_s5;
        r_lnp <= LNP_W'(w_l2m) * LNP_W'(LN2_Q30);
        r_lneg <= r_l2[L2_W-1];
        r_nz7 <= r_nz6;
        r_s7  <= r_s6;
        r_upl <= (DATA_W+LN_W)'(r_s7[DATA_W-1:0]) * (DATA_W+LN_W)'(w_lnm);
        r_uph <= (S_HI_W+LN_W)'(r_s7[S_W-1:DATA_W]) * (S_HI_W+LN_W)'(w_lnm);
        r_uneg8 <= r_lneg;
        r_nz8 <= r_nz7;
        r_um  <= r_nz8 ? w_up[UP_W-1:FRAC_BITS] : '0;
        r_uneg9 <= r_uneg8;
        r_tplx <= (2*DATA_W)'(w_wxm) * (2*DATA_W)'(r_um[DATA_W-1:0]);
        r_tply <= (2*DATA_W)'(w_wym) * (2*DATA_W)'(r_um[DATA_W-1:0]);
        r_tphx <= (DATA_W+U_HI_W)'(w_wxm) * (DATA_W+U_HI_W)'(r_um[U_W-1:DATA_W]);
        r_tphy <= (DATA_W+U_HI_W)'(w_wym) * (DATA_W+U_HI_W)'(r_um[U_W-1:DATA_W]);
        r_tnegx <= r_wpipe[9][DATA_W-1] ^ r_uneg9;
        r_tnegy <= r_wpipe[9][2*DATA_W-1] ^ r_uneg9;
        r_termx <= w_tx.sum;
        r_termy <= w_ty.sum;
        r_tsat  <= w_tx.sat | w_ty.sat;
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[NSTAGE-1:1], i_cmd.issue};
        end
    end

    // Accumulators with a sticky saturation flag.
    logic signed [ACC_W-1:0] r_accx, r_accy;
    logic                    r_sat;
    t_sum                    w_ax, w_ay;

    always_comb begin
        w_ax = add_sat(r_accx, r_termx);
        w_ay = add_sat(r_accy, r_termy);
        if (i_cmd.aff_add1) begin
            w_ax = add_sat(r_accx, w_aterm[0]);
            w_ay = add_sat(r_accy, w_aterm[1]);
        end else if (i_cmd.aff_add2) begin
            w_ax = add_sat(r_accx, w_aterm[2]);
            w_ay = add_sat(r_accy, w_aterm[3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat <= 1'b0;
        end else begin
            priority if (i_cmd.aff_init) begin
                r_accx <= ACC_W'(i_ax_offset);
                r_accy <= ACC_W'(i_ay_offset);
                r_sat  <= 1'b0;
            end else if (i_cmd.aff_add1 || i_cmd.aff_add2) begin
                r_accx <= w_ax.sum;
                r_accy <= w_ay.sum;
                r_sat  <= r_sat | w_ax.sat | w_ay.sat;
            end else if (r_v[NSTAGE]) begin
                r_accx <= w_ax.sum;
                r_accy <= w_ay.sum;
                r_sat  <= r_sat | r_tsat | w_ax.sat | w_ay.sat;
            end else begin
                r_sat  <= r_sat;
            end
        end
    end

    // Output register, clipped to 32 bits.
    t_clip w_cx, w_cy;
    always_comb begin
        w_cx = clip32(r_accx);
        w_cy = clip32(r_accy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            o_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_data.mapped_x  <= w_cx.val;
            o_out_data.mapped_y  <= w_cy.val;
            o_out_data.saturated <= r_sat | w_cx.clip | w_cy.clip;
        end
    end

    // Status to the controller.
    always_comb begin
        o_status.none_to_sum = (w_n == '0);
        o_status.last_issue  = (r_cnt == w_n - CNT_W'(1));
        o_status.pipe_busy   = |r_v;
        o_status.out_busy    = o_out_valid & i_out_stall;
    end

endmodule

### hw/rtl/thin_plate_spline_evaluate.sv
// Evaluation: the accepted beat captures the query; the controller then runs the affine
// multiply, two affine adds, the sum of the n points (skipped with none) through the
// eleven-stage kernel pipeline, its drain and the result load. One evaluation runs at a
// time; the controller waits in a stalled result, and a load leaves it idle.
// Reset (synchronous, active low) clears control state and the registers to their defaults.
// Point memory is not cleared; the user must load slots before reads (not enforced).
`timescale 1ns / 1ps
`include "thin_plate_spline_evaluate_macros.svh"
module thin_plate_spline_evaluate
    import tps_eval_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_beat           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_beat          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    logic [COUNT_W-1:0]       r_point_count;
    logic signed [DATA_W-1:0] r_ax_offset, r_ax_from_x, r_ax_from_y;
    logic signed [DATA_W-1:0] r_ay_offset, r_ay_from_x, r_ay_from_y;
    t_reg_idx                 w_reg_idx;
    t_cmd                     w_cmd;
    t_status                  w_status;

    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
            r_ax_offset   <= '0;
            r_ax_from_x   <= DATA_W'(1 << FRAC_BITS);
            r_ax_from_y   <= '0;
            r_ay_offset   <= '0;
            r_ay_from_x   <= '0;
            r_ay_from_y   <= DATA_W'(1 << FRAC_BITS);
        end else if (psel && penable && pwrite) begin
            unique case (w_reg_idx)
                REG_POINT_COUNT: r_point_count <= pwdata[COUNT_W-1:0];
                REG_AX_OFFSET:   r_ax_offset   <= pwdata;
                REG_AX_FROM_X:   r_ax_from_x   <= pwdata;
                REG_AX_FROM_Y:   r_ax_from_y   <= pwdata;
                REG_AY_OFFSET:   r_ay_offset   <= pwdata;
                REG_AY_FROM_X:   r_ay_from_x   <= pwdata;
                REG_AY_FROM_Y:   r_ay_from_y   <= pwdata;
                default: ;
            endcase
        end
    end

    // Register reads.
    always_comb begin
        unique case (w_reg_idx)
            REG_POINT_COUNT: prdata = DATA_W'(r_point_count);
            REG_AX_OFFSET:   prdata = r_ax_offset;
            REG_AX_FROM_X:   prdata = r_ax_from_x;
            REG_AX_FROM_Y:   prdata = r_ax_from_y;
            REG_AY_OFFSET:   prdata = r_ay_offset;
            REG_AY_FROM_X:   prdata = r_ay_from_x;
            REG_AY_FROM_Y:   prdata = r_ay_from_y;
            default:         prdata = '0;
        endcase
    end

    tps_eval_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_data.action),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_in_stall (o_in_stall)
    );

    tps_eval_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_data     (i_in_data),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_point_count (r_point_count),
        .i_ax_offset   (r_ax_offset),
        .i_ax_from_x   (r_ax_from_x),
        .i_ax_from_y   (r_ax_from_y),
        .i_ay_offset   (r_ay_offset),
        .i_ay_from_x   (r_ay_from_x),
        .i_ay_from_y   (r_ay_from_y),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data)
    );

    // No input beat is taken while points are still in the kernel pipeline.
    `TPS_ASSERT(a_busy_stalls, w_status.pipe_busy |-> o_in_stall, "beat taken while pipe busy")
    // A result is never loaded over one that is still held.
    `TPS_ASSERT(a_no_overwrite, w_cmd.out_load |-> !w_status.out_busy, "result overwritten")
    // Loads and kernel reads never share a cycle.
    `TPS_ASSERT(a_load_vs_issue, !(w_cmd.load && w_cmd.issue), "load during summation")
    // Reset leaves no result pending.
    `TPS_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

### tb/testbench.sv
// Self-checking testbench for the thin plate spline warp evaluator.
`timescale 1ns / 1ps
module testbench;
    import tps_eval_pkg::*;

    localparam int  SLOTS      = 64;
    localparam int  CYCLE_CAP  = 2000000;
    localparam int  SETTLE     = 120;
    localparam int  PHASES     = 10;
    localparam int  PHASE_LEN  = 156;
    localparam logic signed [31:0] S32_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh80000000;
    localparam longint S64_MAX = 64'sh7FFFFFFFFFFFFFFF;
    localparam longint S64_MIN = 64'sh8000000000000000;
    localparam longint LN2_FIX = 744261118;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    t_in_beat           i_in_data;
    logic               o_out_valid;
    logic               i_out_stall;
    t_out_beat          o_out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [DATA_W-1:0]  pwdata;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    thin_plate_spline_evaluate i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Mirror of the block state used for prediction.
    logic [23:0]        mant_log2 [256];
    logic signed [31:0] pt_x [SLOTS];
    logic signed [31:0] pt_y [SLOTS];
    logic signed [31:0] wt_x [SLOTS];
    logic signed [31:0] wt_y [SLOTS];
    logic [6:0]         sum_count;
    longint             coef [2][3];

    t_out_beat          mapped_pending [$];
    int                 fail_count;
    int                 cycle_count;
    bit                 calm;

    typedef struct {
        t_in_beat  beat;
        bit        known;
        t_out_beat want;
    } t_row;

    t_row               plan [$];

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Run length guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Product of two signed values, shifted right toward zero and clipped to 64 bits.
    function automatic longint scale_mul(longint a, longint b, int sh, inout bit sat);
        bit           neg;
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] prod;
        logic [63:0]  lim;
        neg  = (a < 0) != (b < 0);
        ua   = (a < 0) ? 64'(-a) : 64'(a);
        ub   = (b < 0) ? 64'(-b) : 64'(b);
        prod = {64'd0, ua} * {64'd0, ub};
        prod = prod >> sh;
        lim  = neg ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
        if (prod[127:64] != 0 || prod[63:0] > lim) begin
            sat = 1'b1;
            prod[63:0] = lim;
        end
        if (!neg) return longint'(prod[63:0]);
        return longint'(64'd0 - prod[63:0]);
    endfunction

    // Addition clipped to signed 64 bits.
    function automatic longint clip_add(longint a, longint b, inout bit sat);
        logic signed [64:0] total;
        total = 65'(a) + 65'(b);
        if (total > 65'(S64_MAX)) begin
            sat = 1'b1;
            return S64_MAX;
        end
        if (total < 65'(S64_MIN)) begin
            sat = 1'b1;
            return S64_MIN;
        end
        return longint'(total[63:0]);
    endfunction

    // Radial kernel s*ln(s) for a squared distance in unsigned Q48.16.
    function automatic longint radial_term(logic [63:0] s, inout bit sat);
        int          lead;
        logic [63:0] rest;
        logic [63:0] idx;
        longint      l2;
        longint      ln_s;
        if (s == 0) return 0;
        lead = 63;
        while (s[lead] == 1'b0) lead--;
        rest = s - (64'd1 << lead);
        idx  = (lead >= 8) ? (rest >> (lead - 8)) : (rest << (8 - lead));
        idx  = idx & 64'hFF;
        l2   = longint'(lead - FRAC_BITS) * (64'sd1 <<< 24) + longint'(mant_log2[idx[7:0]]);
        ln_s = scale_mul(l2, LN2_FIX, 54 - FRAC_BITS, sat);
        return scale_mul(longint'(s), ln_s, FRAC_BITS, sat);
    endfunction

    // Warped position of one query point under the current spline.
    function automatic t_out_beat warp_point(t_in_beat b);
        t_out_beat   r;
        longint      q [2];
        longint      acc [2];
        longint      u;
        logic [63:0] dx;
        logic [63:0] dy;
        logic [63:0] s;
        bit          sat;
        int          n;
        sat  = 1'b0;
        q[0] = longint'(b.query_x);
        q[1] = longint'(b.query_y);
        n    = (sum_count > SLOTS) ? SLOTS : int'(sum_count);
        for (int c = 0; c < 2; c++) begin
            acc[c] = coef[c][0];
            acc[c] = clip_add(acc[c], scale_mul(coef[c][1], q[0], FRAC_BITS, sat), sat);
            acc[c] = clip_add(acc[c], scale_mul(coef[c][2], q[1], FRAC_BITS, sat), sat);
        end
        for (int i = 0; i < n; i++) begin
            dx = 64'(q[0] - longint'(pt_x[i]));
            dy = 64'(q[1] - longint'(pt_y[i]));
            if (dx[63]) dx = -dx;
            if (dy[63]) dy = -dy;
            s = ((dx * dx) >> FRAC_BITS) + ((dy * dy) >> FRAC_BITS);
            u = radial_term(s, sat);
            acc[0] = clip_add(acc[0], scale_mul(longint'(wt_x[i]), u, FRAC_BITS, sat), sat);
            acc[1] = clip_add(acc[1], scale_mul(longint'(wt_y[i]), u, FRAC_BITS, sat), sat);
        end
        for (int c = 0; c < 2; c++) begin
            if (acc[c] > longint'(S32_MAX)) begin
                acc[c] = S32_MAX;
                sat = 1'b1;
            end
            if (acc[c] < longint'(S32_MIN)) begin
                acc[c] = S32_MIN;
                sat = 1'b1;
            end
        end
        r.mapped_x  = acc[0][31:0];
        r.mapped_y  = acc[1][31:0];
        r.saturated = sat;
        return r;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_len();
        int pick;
        if (calm) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 50) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Coordinate or weight value: mostly moderate, sometimes full range or extreme.
    function automatic logic signed [31:0] pick_value();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return $signed($urandom) >>> 11;
        if (pick < 85) return $urandom;
        case ($urandom_range(0, 3))
            0: return S32_MAX;
            1: return S32_MIN;
            2: return 32'sd0;
            default: return -32'sd1;
        endcase
    endfunction

    function automatic t_in_beat make_beat(t_action act, logic [5:0] slot);
        t_in_beat b;
        b.action      = act;
        b.entry_index = slot;
        b.ctrl_x      = pick_value();
        b.ctrl_y      = pick_value();
        b.weight_x    = pick_value();
        b.weight_y    = pick_value();
        b.query_x     = pick_value();
        b.query_y     = pick_value();
        return b;
    endfunction

    // Send one beat, then update the mirror and queue what it should produce.
    task automatic send_beat(t_row row);
        int        gap;
        t_out_beat want_beat;
        gap = idle_len();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_data  = row.beat;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!(i_in_valid && !o_in_stall));
        if (row.beat.action == ACT_LOAD) begin
            pt_x[row.beat.entry_index] = row.beat.ctrl_x;
            pt_y[row.beat.entry_index] = row.beat.ctrl_y;
            wt_x[row.beat.entry_index] = row.beat.weight_x;
            wt_y[row.beat.entry_index] = row.beat.weight_y;
        end else begin
            want_beat      = row.known ? row.want : warp_point(row.beat);
            mapped_pending = {mapped_pending, want_beat};
        end
        @(negedge i_clk);
    endtask

    // Wait until every result is back and the block has settled.
    task automatic drain();
        i_in_valid = 1'b0;
        @(negedge i_clk);
        while (mapped_pending.size() > 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // Two-phase register write on the configuration port.
    task automatic reg_write(t_reg_idx idx, logic [31:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = PADDR_W'(4 * int'(idx));
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (idx == REG_POINT_COUNT) sum_count = value[6:0];
        else coef[(int'(idx) - 1) / 3][(int'(idx) - 1) % 3] = longint'($signed(value));
    endtask

    // Affine coefficient for a phase: extremes on some phases, else mostly near identity.
    function automatic logic [31:0] pick_coef(int phase, bit diag);
        if (phase == 1) return S32_MAX;
        if (phase == 2) return S32_MIN;
        if ($urandom_range(0, 9) == 0) return $urandom;
        return (diag ? 32'sd65536 : 32'sd0) + ($signed($urandom) >>> 14);
    endfunction

    // Result check against the oldest expectation.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (mapped_pending.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, o_out_data);
                fail_count++;
            end else begin
                want = mapped_pending.pop_front();
                if (o_out_data.mapped_x !== want.mapped_x) begin
                    $display("%0t: mapped_x expected %h got %h", $time,
                             want.mapped_x, o_out_data.mapped_x);
                    fail_count++;
                end
                if (o_out_data.mapped_y !== want.mapped_y) begin
                    $display("%0t: mapped_y expected %h got %h", $time,
                             want.mapped_y, o_out_data.mapped_y);
                    fail_count++;
                end
                if (o_out_data.saturated !== want.saturated) begin
                    $display("%0t: saturated expected %b got %b", $time,
                             want.saturated, o_out_data.saturated);
                    fail_count++;
                end
            end
        end
    end

    // Receiver back-pressure in runs.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                i_out_stall = 1'b1;
                repeat (idle_len()) @(negedge i_clk);
                i_out_stall = 1'b0;
            end
        end
    end

    // Main sequence.
    initial begin
        t_row        row;
        logic [63:0] y;
        logic [23:0] frac;
        int          pick;
        logic [6:0]  cnt;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        fail_count  = 0;
        cycle_count = 0;
        calm        = 1'b0;

        // Mantissa table of log2(1 + k/256), Q0.24, by repeated squaring.
        for (int k = 0; k < 256; k++) begin
            y    = (64'd1 << 30) + (64'(k) << 22);
            frac = '0;
            for (int bit_no = 1; bit_no <= 24; bit_no++) begin
                y = (y * y) >> 30;
                if (y >= (64'd1 << 31)) begin
                    frac[24 - bit_no] = 1'b1;
                    y = y >> 1;
                end
            end
            mant_log2[k] = frac;
        end
        for (int i = 0; i < SLOTS; i++) begin
            pt_x[i] = '0;
            pt_y[i] = '0;
            wt_x[i] = '0;
            wt_y[i] = '0;
        end
        sum_count  = '0;
        coef[0][0] = 0;
        coef[0][1] = 65536;
        coef[0][2] = 0;
        coef[1][0] = 0;
        coef[1][1] = 0;
        coef[1][2] = 65536;

        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed rows: with no points and the identity map, a query maps to itself.
        row.known = 1'b1;
        for (int i = 0; i < 6; i++) begin
            row.beat = make_beat(ACT_EVAL, 6'($urandom));
            case (i)
                0: begin row.beat.query_x = 32'sd0;        row.beat.query_y = 32'sd0;        end
                1: begin row.beat.query_x = S32_MAX;       row.beat.query_y = S32_MIN;       end
                2: begin row.beat.query_x = S32_MIN;       row.beat.query_y = S32_MAX;       end
                3: begin row.beat.query_x = -32'sd1;       row.beat.query_y = 32'sd1;        end
                4: begin row.beat.query_x = 32'sh55555555; row.beat.query_y = 32'shAAAAAAAA; end
                default: begin
                    row.beat.query_x = 32'shAAAAAAAA;
                    row.beat.query_y = 32'sh55555555;
                end
            endcase
            row.want.mapped_x  = row.beat.query_x;
            row.want.mapped_y  = row.beat.query_y;
            row.want.saturated = 1'b0;
            plan = {plan, row};
        end
        // Loads with extreme fields; they give no result.
        row.known = 1'b0;
        for (int i = 0; i < 8; i++) begin
            row.beat = make_beat(ACT_LOAD, (i % 2) ? 6'h3F : 6'h00);
            row.beat.ctrl_x   = (i & 1) ? S32_MAX : S32_MIN;
            row.beat.ctrl_y   = (i & 2) ? S32_MAX : S32_MIN;
            row.beat.weight_x = (i & 4) ? S32_MAX : S32_MIN;
            row.beat.weight_y = (i & 2) ? S32_MIN : S32_MAX;
            row.beat.query_x  = (i & 1) ? 32'sh55555555 : 32'shAAAAAAAA;
            row.beat.query_y  = (i & 1) ? 32'shAAAAAAAA : 32'sh55555555;
            plan = {plan, row};
        end
        row.beat = make_beat(ACT_LOAD, 6'h2A);
        plan = {plan, row};
        row.beat = make_beat(ACT_LOAD, 6'h15);
        plan = {plan, row};
        foreach (plan[i]) send_beat(plan[i]);

        // Fill every slot so any point count reads only loaded entries.
        for (int i = 0; i < SLOTS; i++) begin
            row.beat = make_beat(ACT_LOAD, 6'(i));
            send_beat(row);
        end

        // Random phases, each with its own register setting.
        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            case (phase)
                0: cnt = 7'd1;
                1: cnt = 7'd64;
                2: cnt = 7'd127;
                3: cnt = 7'd0;
                default: cnt = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                                           : 7'($urandom_range(1, 8));
            endcase
            reg_write(REG_POINT_COUNT, 32'(cnt));
            reg_write(REG_AX_OFFSET, pick_coef(phase, 1'b0) <<< 4);
            reg_write(REG_AX_FROM_X, pick_coef(phase, 1'b1));
            reg_write(REG_AX_FROM_Y, pick_coef(phase, 1'b0));
            reg_write(REG_AY_OFFSET, pick_coef(phase, 1'b0) <<< 4);
            reg_write(REG_AY_FROM_X, pick_coef(phase, 1'b0));
            reg_write(REG_AY_FROM_Y, pick_coef(phase, 1'b1));
            calm = (phase % 4) == 3;
            for (int n = 0; n < PHASE_LEN; n++) begin
                pick = $urandom_range(0, 99);
                row.beat = make_beat((pick < 30) ? ACT_LOAD : ACT_EVAL, 6'($urandom));
                send_beat(row);
            end
        end
        calm = 1'b0;

        // Final drain, then verdict.
        drain();
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
